FILE: hdl/hsvr_pkg.sv
package hsvr_pkg;

   // input word: one pixel in hsv
   typedef struct packed {
      logic [7:0] hue_in;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } req_type;

   // result word: one pixel in rgb
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // scaled ramps of one section, floor not yet added
   typedef struct packed {
      logic [7:0] up;
      logic [7:0] dn;
   } ramp_type;

   // hue section codes (scaled hue bits 7:6)
   localparam logic [1:0] SECT_RED_GREEN  = 2'd0;
   localparam logic [1:0] SECT_GREEN_BLUE = 2'd1;
   localparam logic [1:0] SECT_BLUE_RED   = 2'd2;

   // hue scaling: 192/256 reduces to 3/4
   localparam logic [9:0] HUE_MUL      = 10'd3;
   localparam int         HUE_SHIFT    = 2;
   localparam logic [5:0] SECT_OFF_MAX = 6'h3F;
   localparam int         RAMP_SHIFT   = 6;
   localparam logic [7:0] CHAN_MAX     = 8'hFF;

endpackage

FILE: hdl/hsvr_ramp.sv
module hsvr_ramp
   import hsvr_pkg::*;
(
   input  logic [5:0] off,
   input  logic [7:0] amp,
   output ramp_type   ramp
);

   logic [13:0] up_prod;
   logic [13:0] dn_prod;
   logic [5:0]  dn_off;

   // ramp-down offset mirrors the ramp-up offset
   assign dn_off = SECT_OFF_MAX - off;

   // both ramps scaled by amplitude / 64
   assign up_prod = {8'd0, off} * {6'd0, amp};
   assign dn_prod = {8'd0, dn_off} * {6'd0, amp};

   assign ramp.up = up_prod[13:RAMP_SHIFT];
   assign ramp.dn = dn_prod[13:RAMP_SHIFT];

endmodule

FILE: hdl/hsv_rainbow_to_rgb.sv
// channel | direction | handshake            | word
// req     | in        | req_valid, req_ready | req_word (hue_in, saturation, brightness)
// rsp     | out       | rsp_valid, rsp_ready | rsp_word (red, green, blue)
//
// three register stages: hue scale and floor multiply, ramp multiplies, floor add and routing
// one word accepted per clock when the output is taken; a word passes the stage 1, 2 and 3 registers in order
// each stage holds its word while the next one is full and stalled, so bubbles are filled
// reset is synchronous and clears only the stage valid bits
module hsv_rainbow_to_rgb
   import hsvr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic        v1_ff, v1_in;
   logic [7:0]  h1_ff, h1_in;
   logic [7:0]  floor1_ff, floor1_in;
   logic [7:0]  bri1_ff;

   logic        v2_ff, v2_in;
   logic [1:0]  sect2_ff;
   logic [7:0]  floor2_ff;
   ramp_type    ramp2_ff, ramp2_in;

   logic        v3_ff, v3_in;
   rsp_type     rsp_ff, rsp_in;

   logic        rdy1, rdy2, rdy3;
   logic [9:0]  hue_prod;
   logic [15:0] floor_prod;
   logic [7:0]  amp;
   logic [8:0]  up_sum;
   logic [8:0]  dn_sum;

   // stage enables, back from the output
   assign rdy3      = !v3_ff || rsp_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   // stage 1: scaled hue and brightness floor
   assign hue_prod   = {2'd0, req_word.hue_in} * HUE_MUL;
   assign floor_prod = {8'd0, req_word.brightness} * {8'd0, CHAN_MAX - req_word.saturation};
   assign h1_in      = hue_prod[9:HUE_SHIFT];
   assign floor1_in  = floor_prod[15:8];
   assign v1_in      = rdy1 ? req_valid : v1_ff;

   // stage 2: amplitude and ramp products
   assign amp   = bri1_ff - floor1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;

   hsvr_ramp u_ramp (
      .off  (h1_ff[5:0]),
      .amp  (amp),
      .ramp (ramp2_in)
   );

   // stage 3: add floor and route per section
   assign up_sum = {1'b0, ramp2_ff.up} + {1'b0, floor2_ff};
   assign dn_sum = {1'b0, ramp2_ff.dn} + {1'b0, floor2_ff};
   assign v3_in  = rdy3 ? v2_ff : v3_ff;

   always_comb begin
      case (sect2_ff)
         SECT_RED_GREEN: begin
            rsp_in.red   = dn_sum[7:0];
            rsp_in.green = up_sum[7:0];
            rsp_in.blue  = floor2_ff;
         end
         SECT_GREEN_BLUE: begin
            rsp_in.red   = floor2_ff;
            rsp_in.green = dn_sum[7:0];
            rsp_in.blue  = up_sum[7:0];
         end
         default: begin
            rsp_in.red   = up_sum[7:0];
            rsp_in.green = floor2_ff;
            rsp_in.blue  = dn_sum[7:0];
         end
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (rdy1) begin
         h1_ff     <= h1_in;
         floor1_ff <= floor1_in;
         bri1_ff   <= req_word.brightness;
      end
      if (rdy2) begin
         sect2_ff  <= h1_ff[7:6];
         floor2_ff <= floor1_ff;
         ramp2_ff  <= ramp2_in;
      end
      if (rdy3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_word  = rsp_ff;

   // floor never exceeds brightness, so amplitude cannot wrap
   a_floor_le_bri: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> floor1_ff <= bri1_ff)
      else $error("floor above brightness");

   // scaled hue stays below the unused fourth section
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> h1_ff[7:6] <= SECT_BLUE_RED)
      else $error("scaled hue out of range");

   // a stalled output keeps the stage behind it full and unchanged
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v3_ff && !rsp_ready) |=> (v2_ff && $stable(ramp2_ff) && $stable(floor2_ff)))
      else $error("stage 2 lost a word during stall");

   // stage 1 holds when both later stages are full and stalled
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && !rsp_ready) |=> (v1_ff && $stable(h1_ff)))
      else $error("stage 1 lost a word during stall");

endmodule
